// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drive command frame parser: assertion failed");

// Next-cycle implication, disabled during reset
`define DCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drive command frame parser: assertion failed");

`endif

// ----- hw/rtl/dcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// dcfp_pkg
// Types and constants of the drive command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfp_pkg;

	// Frame start bytes
	localparam logic [7:0] START_DRIVE = 8'h23;  // '#'
	localparam logic [7:0] START_CMD   = 8'h26;  // '&'

	// Command codes
	localparam logic [7:0] DBG_ON_C0  = 8'd38;
	localparam logic [7:0] DBG_ON_C1  = 8'd79;
	localparam logic [7:0] DBG_ON_C2  = 8'd123;
	localparam logic [7:0] DBG_OFF_C0 = 8'd31;
	localparam logic [7:0] DBG_OFF_C1 = 8'd39;
	localparam logic [7:0] DBG_OFF_C2 = 8'd115;
	localparam logic [7:0] STOP_A_C0  = 8'd67;
	localparam logic [7:0] STOP_A_C1  = 8'd89;
	localparam logic [7:0] STOP_A_C2  = 8'd23;
	localparam logic [7:0] STOP_B_C0  = 8'd34;
	localparam logic [7:0] STOP_B_C1  = 8'd63;
	localparam logic [7:0] STOP_B_C2  = 8'd129;

	// Per-item event codes
	typedef enum logic [3:0] {
		EV_INFRAME  = 4'd0,
		EV_DISCARD  = 4'd1,
		EV_DRIVE_OK = 4'd2,
		EV_BAD_CK   = 4'd3,
		EV_DBG_ON   = 4'd4,
		EV_DBG_OFF  = 4'd5,
		EV_STOP     = 4'd6,
		EV_UNKNOWN  = 4'd7,
		EV_ABORT    = 4'd8
	} dcfp_event_t;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SPEED = 3'd1,
		PH_STEER = 3'd2,
		PH_CHECK = 3'd3,
		PH_CMD0  = 3'd4,
		PH_CMD1  = 3'd5,
		PH_CMD2  = 3'd6
	} dcfp_phase_t;

	// Input item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       link_lost;
	} dcfp_in_t;

	// Result item
	typedef struct packed {
		logic [7:0] speed_now;
		logic [7:0] steer_now;
		logic       debug_on;
		logic [3:0] frame_event;
	} dcfp_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/drive_command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// drive_command_frame_parser
// Finds drive and command frames in a serial byte stream and keeps the
// speed, steer and debug registers; one result item per input byte.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------
//  input   | in_valid  | in_ready  | in_data  (rx_byte, link_lost)
//  output  | out_valid | out_ready | out_data (speed, steer, dbg, event)
//
//  One item per cycle sustained while the output is not stalled; a result is
//  offered once its byte has passed the input register, then the result register.
//  All parsing is one pass of logic between the input and result registers.
//  arst_n clears phase, speed, steer, debug flag and the valid bits.
//  A stalled output holds its result; the input register still frees up
//  whenever the result register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_frame_parser (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  dcfp_pkg::dcfp_in_t    in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output dcfp_pkg::dcfp_out_t   out_data
);
	import dcfp_pkg::*;

	logic         valid_s1;
	dcfp_in_t     data_s1;
	logic         out_valid_q;
	dcfp_out_t    out_data_q;
	logic         advance;
	logic         in_fire;

	dcfp_phase_t  phase_q, phase_d;
	logic [7:0]   held0_q, held1_q;
	logic         held0_we, held1_we;
	logic [7:0]   speed_q, speed_d;
	logic [7:0]   steer_q, steer_d;
	logic         debug_q, debug_d;
	dcfp_event_t  ev;
	logic [7:0]   check_sum;

	// Handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= in_data;
		end
	end

	// Drive frame checksum: speed + 2*steer, mod 256
	assign check_sum = held0_q + {held1_q[6:0], 1'b0};

	// Parser next state and event
	always_comb begin
		phase_d  = PH_IDLE;
		held0_we = 1'b0;
		held1_we = 1'b0;
		speed_d  = speed_q;
		steer_d  = steer_q;
		debug_d  = debug_q;
		ev       = EV_INFRAME;
		if (data_s1.link_lost) begin
			ev = (phase_q == PH_IDLE || phase_q > PH_CMD2) ? EV_DISCARD : EV_ABORT;
		end else begin
			unique case (phase_q)
				PH_SPEED, PH_CMD0: begin
					held0_we = 1'b1;
					phase_d  = (phase_q == PH_SPEED) ? PH_STEER : PH_CMD1;
				end
				PH_STEER, PH_CMD1: begin
					held1_we = 1'b1;
					phase_d  = (phase_q == PH_STEER) ? PH_CHECK : PH_CMD2;
				end
				PH_CHECK: begin
					if (check_sum == data_s1.rx_byte) begin
						speed_d = held0_q;
						steer_d = held1_q;
						ev      = EV_DRIVE_OK;
					end else begin
						ev = EV_BAD_CK;
					end
				end
				PH_CMD2: begin
					if (held0_q == DBG_ON_C0 && held1_q == DBG_ON_C1
					    && data_s1.rx_byte == DBG_ON_C2) begin
						debug_d = 1'b1;
						ev      = EV_DBG_ON;
					end else if (held0_q == DBG_OFF_C0 && held1_q == DBG_OFF_C1
					    && data_s1.rx_byte == DBG_OFF_C2) begin
						debug_d = 1'b0;
						ev      = EV_DBG_OFF;
					end else if ((held0_q == STOP_A_C0 && held1_q == STOP_A_C1
					    && data_s1.rx_byte == STOP_A_C2)
					    || (held0_q == STOP_B_C0 && held1_q == STOP_B_C1
					    && data_s1.rx_byte == STOP_B_C2)) begin
						speed_d = 8'd0;
						steer_d = 8'd0;
						ev      = EV_STOP;
					end else begin
						ev = EV_UNKNOWN;
					end
				end
				default: begin
					// idle, and the unused phase code treated as idle
					if (data_s1.rx_byte == START_DRIVE) begin
						phase_d = PH_SPEED;
					end else if (data_s1.rx_byte == START_CMD) begin
						phase_d = PH_CMD0;
					end else begin
						ev = EV_DISCARD;
					end
				end
			endcase
		end
	end

	// Parser state, updated as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			speed_q <= 8'd0;
			steer_q <= 8'd0;
			debug_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			speed_q <= speed_d;
			steer_q <= steer_d;
			debug_q <= debug_d;
		end
	end

	// Held payload bytes, always written before read
	always_ff @(posedge clk) begin
		if (advance && held0_we) begin
			held0_q <= data_s1.rx_byte;
		end
		if (advance && held1_we) begin
			held1_q <= data_s1.rx_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.speed_now   <= speed_d;
			out_data_q.steer_now   <= steer_d;
			out_data_q.debug_on    <= debug_d;
			out_data_q.frame_event <= ev;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dcfp_checker.sv -----
// ----------------------------------------------------------------------------
// dcfp_checker
// Port-level checks of the drive command frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dcfp_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_ready,
	input  dcfp_pkg::dcfp_in_t    in_data,
	input  wire                   out_valid,
	input  wire                   out_ready,
	input  dcfp_pkg::dcfp_out_t   out_data
);
	import dcfp_pkg::*;

	logic in_wait;
	logic out_wait;
	logic stop_seen;
	logic dbg_on_seen;
	logic dbg_off_seen;
	logic drive_zero;

	assign in_wait      = in_valid && !in_ready;
	assign out_wait     = out_valid && !out_ready;
	assign stop_seen    = out_valid && out_data.frame_event == EV_STOP;
	assign dbg_on_seen  = out_valid && out_data.frame_event == EV_DBG_ON;
	assign dbg_off_seen = out_valid && out_data.frame_event == EV_DBG_OFF;
	assign drive_zero   = out_data.speed_now == 8'd0 && out_data.steer_now == 8'd0;

	// A stalled result holds
	`DCFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_data))

	// A waiting input item holds
	`DCFP_ASSERT_NEXT(a_in_hold, clk, arst_n, in_wait, in_valid && $stable(in_data))

	// Stop command leaves speed and steer at zero
	`DCFP_ASSERT_IMP(a_stop_zero, clk, arst_n, stop_seen, drive_zero)

	// Debug commands show in the flag of the same item
	`DCFP_ASSERT_IMP(a_dbg_on, clk, arst_n, dbg_on_seen, out_data.debug_on)

	`DCFP_ASSERT_IMP(a_dbg_off, clk, arst_n, dbg_off_seen, !out_data.debug_on)

endmodule

bind drive_command_frame_parser dcfp_checker u_dcfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ----- dv/drive_command_frame_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_frame_parser_tb
// Self-checking bench for the drive command frame parser. A queue of bytes
// (directed frames first, then random frames, noise and broken frames) feeds
// a clocked driver; a predictor tracks phase, speed, steer and debug state
// and a clocked monitor checks every result item in order. Idling runs in
// phases on both channels, with one long output hold-off.
// ----------------------------------------------------------------------------
module drive_command_frame_parser_tb;
	import dcfp_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Idling pattern, carried by each queued item
	typedef enum logic [2:0] {
		PACE_FREE,
		PACE_TX_IDLE,
		PACE_RX_STALL,
		PACE_HOLD,
		PACE_BOTH
	} pace_mode_t;

	typedef struct {
		dcfp_in_t   item;
		pace_mode_t mode;
	} pending_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	dcfp_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	dcfp_out_t out_data;

	pending_t   pending_bytes[$];
	dcfp_out_t  expected_results[$];
	pace_mode_t fill_mode   = PACE_FREE;
	pace_mode_t pace_mode   = PACE_FREE;
	logic       hold_active = 1'b0;
	logic       hold_done   = 1'b0;
	int         hold_count  = 0;
	int         cycle_count = 0;
	bit         failed      = 1'b0;

	// Predicted parser state
	dcfp_phase_t prs_phase = PH_IDLE;
	logic [7:0]  held_first  = '0;
	logic [7:0]  held_second = '0;
	logic [7:0]  prs_speed   = '0;
	logic [7:0]  prs_steer   = '0;
	logic        prs_debug   = 1'b0;

	drive_command_frame_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// Predictor: advance the parser state by one byte
	task automatic parse_byte(input dcfp_in_t item, output dcfp_out_t res);
		dcfp_event_t ev;
		logic [7:0]  b;
		logic [7:0]  sum;
		b  = item.rx_byte;
		ev = EV_INFRAME;
		if (item.link_lost) begin
			ev = (prs_phase != PH_IDLE) ? EV_ABORT : EV_DISCARD;
			prs_phase = PH_IDLE;
		end else begin
			case (prs_phase)
				PH_SPEED: begin
					held_first = b;
					prs_phase  = PH_STEER;
				end
				PH_STEER: begin
					held_second = b;
					prs_phase   = PH_CHECK;
				end
				PH_CHECK: begin
					sum = held_first + (held_second << 1);
					if (sum == b) begin
						prs_speed = held_first;
						prs_steer = held_second;
						ev = EV_DRIVE_OK;
					end else begin
						ev = EV_BAD_CK;
					end
					prs_phase = PH_IDLE;
				end
				PH_CMD0: begin
					held_first = b;
					prs_phase  = PH_CMD1;
				end
				PH_CMD1: begin
					held_second = b;
					prs_phase   = PH_CMD2;
				end
				PH_CMD2: begin
					if (held_first == DBG_ON_C0 && held_second == DBG_ON_C1
							&& b == DBG_ON_C2) begin
						prs_debug = 1'b1;
						ev = EV_DBG_ON;
					end else if (held_first == DBG_OFF_C0 && held_second == DBG_OFF_C1
							&& b == DBG_OFF_C2) begin
						prs_debug = 1'b0;
						ev = EV_DBG_OFF;
					end else if ((held_first == STOP_A_C0 && held_second == STOP_A_C1
							&& b == STOP_A_C2) || (held_first == STOP_B_C0
							&& held_second == STOP_B_C1 && b == STOP_B_C2)) begin
						prs_speed = '0;
						prs_steer = '0;
						ev = EV_STOP;
					end else begin
						ev = EV_UNKNOWN;
					end
					prs_phase = PH_IDLE;
				end
				default: begin
					if (b == START_DRIVE) begin
						prs_phase = PH_SPEED;
					end else if (b == START_CMD) begin
						prs_phase = PH_CMD0;
					end else begin
						prs_phase = PH_IDLE;
						ev = EV_DISCARD;
					end
				end
			endcase
		end
		res.speed_now   = prs_speed;
		res.steer_now   = prs_steer;
		res.debug_on    = prs_debug;
		res.frame_event = ev;
	endtask

	// Stimulus helpers
	task automatic push_byte(input logic [7:0] b, input logic lost);
		pending_t p;
		p.item.rx_byte   = b;
		p.item.link_lost = lost;
		p.mode           = fill_mode;
		pending_bytes.push_back(p);
	endtask

	task automatic push_drive(input logic [7:0] spd, input logic [7:0] str, input bit good);
		logic [7:0] ck;
		ck = spd + (str << 1);
		if (!good)
			ck = ck ^ 8'($urandom_range(1, 255));
		push_byte(START_DRIVE, 1'b0);
		push_byte(spd, 1'b0);
		push_byte(str, 1'b0);
		push_byte(ck, 1'b0);
	endtask

	task automatic push_cmd(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
		push_byte(START_CMD, 1'b0);
		push_byte(c0, 1'b0);
		push_byte(c1, 1'b0);
		push_byte(c2, 1'b0);
	endtask

	task automatic push_magic(input int which, input bit spoil_last);
		logic [7:0] c0, c1, c2;
		case (which)
			0: begin c0 = DBG_ON_C0;  c1 = DBG_ON_C1;  c2 = DBG_ON_C2;  end
			1: begin c0 = DBG_OFF_C0; c1 = DBG_OFF_C1; c2 = DBG_OFF_C2; end
			2: begin c0 = STOP_A_C0;  c1 = STOP_A_C1;  c2 = STOP_A_C2;  end
			default: begin c0 = STOP_B_C0; c1 = STOP_B_C1; c2 = STOP_B_C2; end
		endcase
		if (spoil_last)
			c2 = c2 ^ 8'(1 << $urandom_range(0, 7));
		push_cmd(c0, c1, c2);
	endtask

	function automatic int sender_idle_pct(input pace_mode_t m);
		case (m)
			PACE_TX_IDLE: return 54;
			PACE_BOTH:    return 29;
			default:      return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input pace_mode_t m);
		case (m)
			PACE_RX_STALL: return 54;
			PACE_BOTH:     return 29;
			default:       return 0;
		endcase
	endfunction

	// Driver: predict on acceptance, then offer the next queued item
	always @(posedge clk) begin
		dcfp_out_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(in_data, res);
				expected_results.push_back(res);
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_bytes.size() != 0
						&& $urandom_range(0, 99) >= sender_idle_pct(pending_bytes[0].mode)) begin
					pace_mode <= pending_bytes[0].mode;
					in_data   <= pending_bytes[0].item;
					in_valid  <= 1'b1;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// One long output hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_done   <= 1'b0;
			hold_count  <= 0;
		end else if (!hold_done && pace_mode == PACE_HOLD) begin
			hold_count  <= hold_count + 1;
			hold_active <= (hold_count != HOLD_CYCLES - 1);
			hold_done   <= (hold_count == HOLD_CYCLES - 1);
		end
	end

	// Receiver ready
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_active && ($urandom_range(0, 99) >= receiver_stall_pct(pace_mode));
	end

	// Monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin
		dcfp_out_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item: speed %0d steer %0d debug %0d event %0d",
					out_data.speed_now, out_data.steer_now, out_data.debug_on,
					out_data.frame_event);
				failed = 1'b1;
			end else begin
				exp_res = expected_results.pop_front();
				if (out_data.speed_now !== exp_res.speed_now) begin
					$error("speed_now: expected %0d, actual %0d",
						exp_res.speed_now, out_data.speed_now);
					failed = 1'b1;
				end
				if (out_data.steer_now !== exp_res.steer_now) begin
					$error("steer_now: expected %0d, actual %0d",
						exp_res.steer_now, out_data.steer_now);
					failed = 1'b1;
				end
				if (out_data.debug_on !== exp_res.debug_on) begin
					$error("debug_on: expected %0d, actual %0d",
						exp_res.debug_on, out_data.debug_on);
					failed = 1'b1;
				end
				if (out_data.frame_event !== exp_res.frame_event) begin
					$error("frame_event: expected %0d, actual %0d",
						exp_res.frame_event, out_data.frame_event);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus fill, reset, and end of run
	initial begin
		int base;
		int idx;
		int kind;
		int n;

		// Directed: extremes, every command, special cases
		fill_mode = PACE_FREE;
		push_byte(8'h00, 1'b1);            // link lost while idle
		push_byte(8'hFF, 1'b0);            // noise outside a frame
		push_drive(8'hFF, 8'hFF, 1'b1);
		push_byte(START_DRIVE, 1'b0);      // start bytes taken as payload
		push_byte(START_DRIVE, 1'b0);
		push_byte(START_DRIVE, 1'b0);
		push_byte(8'h00, 1'b0);            // bad check
		push_magic(0, 1'b0);
		push_magic(2, 1'b0);
		push_drive(8'h00, 8'h80, 1'b1);
		push_magic(3, 1'b0);
		push_magic(1, 1'b0);
		push_cmd(8'hFF, 8'h00, 8'h00);     // unknown command
		push_byte(START_CMD, 1'b0);        // frame aborted by link loss
		push_byte(DBG_ON_C0, 1'b0);
		push_byte(8'hFF, 1'b1);

		// Random: mostly well-formed frames with random content
		base = pending_bytes.size();
		while (pending_bytes.size() - base < RANDOM_ITEMS) begin
			idx = (pending_bytes.size() - base) * 5 / RANDOM_ITEMS;
			if (idx > 4)
				idx = 4;
			fill_mode = pace_mode_t'(idx);
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				push_drive(8'($urandom), 8'($urandom), $urandom_range(0, 99) < 75);
			end else if (kind < 70) begin
				case ($urandom_range(0, 2))
					0: push_magic($urandom_range(0, 3), 1'b0);
					1: push_magic($urandom_range(0, 3), 1'b1);
					default: push_cmd(8'($urandom), 8'($urandom), 8'($urandom));
				endcase
			end else if (kind < 85) begin
				push_byte(8'($urandom), 1'b0);
			end else if (kind < 95) begin
				// broken frame: start, up to two payload bytes, then link loss
				push_byte($urandom_range(0, 1) ? START_DRIVE : START_CMD, 1'b0);
				n = $urandom_range(0, 2);
				repeat (n) push_byte(8'($urandom), 1'b0);
				push_byte(8'($urandom), 1'b1);
			end else begin
				push_byte(8'($urandom), 1'b1);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the queue to drain and all results to arrive
		@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d result items never arrived", expected_results.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dcfp_pkg.sv
hw/rtl/drive_command_frame_parser.sv
hw/rtl/dcfp_checker.sv
dv/drive_command_frame_parser_tb.sv
